// File: sv/vumb_pkg.sv
// ----------------------------------------------------------------------------
// vumb_pkg - shared definitions for the VU meter bar driver
// Field widths, register indexes, codes, colours and the types that travel
// between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package vumb_pkg;

  // Default geometry
  localparam int STRIP_LEDS_DEF    = 64;
  localparam int PALETTE_DEPTH_DEF = 256;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int LEVEL_W  = 16;
  localparam int SLOT_W   = 8;
  localparam int COLOR_W  = 24;
  localparam int INDEX_W  = 6;
  localparam int BRIGHT_W = 8;
  localparam int LEN_W    = 7;
  localparam int SECS_W   = 16;
  localparam int PSIZE_W  = 9;
  localparam int MODE_W   = 2;
  localparam int REGIDX_W = 3;
  localparam int CFGDAT_W = 24;
  localparam int EXP_W    = 4;
  localparam int FRAC_W   = 8;
  localparam int L8_W     = EXP_W + FRAC_W;
  localparam int THR_W    = 18;
  localparam int MANT_W   = 32;
  localparam int PCT_W    = 13;

  // Full scale of the log domain: 15 octaves in Q.8
  localparam int FULL_LOG = 3840;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_LEVEL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd2;

  // Colour modes
  localparam logic [MODE_W-1:0] MODE_FIXED    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEQUENCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEEP     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GRADIENT = 2'd3;

  // Register indexes
  localparam logic [REGIDX_W-1:0] REG_COLOR_MODE      = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_FIXED_COLOR     = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_LIT_BRIGHTNESS  = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_FIRST_LED       = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_BAR_LENGTH      = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_RECOLOR_SECONDS = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_PALETTE_SIZE    = 3'd6;

  // Gradient band limits in percent of the bar, and the full percentage
  localparam int GRAD_RED_PCT    = 85;
  localparam int GRAD_ORANGE_PCT = 80;
  localparam int GRAD_YELLOW_PCT = 75;
  localparam int GRAD_LIME_PCT   = 70;
  localparam int PCT_FULL        = 100;

  localparam logic [COLOR_W-1:0] COL_RED    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COL_ORANGE = 24'hFF8000;
  localparam logic [COLOR_W-1:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] COL_LIME   = 24'h80FF00;
  localparam logic [COLOR_W-1:0] COL_GREEN  = 24'h00FF00;

  // Reset values
  localparam logic [COLOR_W-1:0] LIVE_COLOUR_RST = 24'h0000FF;

  // Job queue depth between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode_sel;
    logic [COLOR_W-1:0]  fixed_color;
    logic [BRIGHT_W-1:0] lit_brightness;
    logic [INDEX_W-1:0]  first_led;
    logic [LEN_W-1:0]    bar_length;
    logic [SECS_W-1:0]   recolor_seconds;
    logic [PSIZE_W-1:0]  palette_size;
  } cfg_regs_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic [THR_W-1:0]    thr;       // L8 * len
    logic                lit_en;    // level is non-zero
    logic [BRIGHT_W-1:0] bright;
    logic                cw;        // colour write
    logic                grad;      // gradient colouring
    logic [COLOR_W-1:0]  color;
  } job_t;

endpackage

`default_nettype wire

// File: sv/vumb_if.sv
// ----------------------------------------------------------------------------
// vumb_if - channel interfaces of the VU meter bar driver
// Sample input channel, LED result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface vumb_in_if;
  import vumb_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [LEVEL_W-1:0] level;
  logic [SLOT_W-1:0]  slot;
  logic [COLOR_W-1:0] color_value;

  modport source (output valid, kind, level, slot, color_value, input ready);
  modport sink   (input valid, kind, level, slot, color_value, output ready);
endinterface

interface vumb_out_if;
  import vumb_pkg::*;

  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  led_index;
  logic [COLOR_W-1:0]  led_color;
  logic                color_write;
  logic [BRIGHT_W-1:0] led_brightness;
  logic                last;

  modport source (output valid, led_index, led_color, color_write, led_brightness, last,
                  input ready);
  modport sink   (input valid, led_index, led_color, color_write, led_brightness, last,
                  output ready);
endinterface

interface vumb_cfg_if;
  import vumb_pkg::*;

  logic                valid;
  logic                ready;
  logic [REGIDX_W-1:0] index;
  logic [CFGDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/vumb_ram.sv
// ----------------------------------------------------------------------------
// vumb_ram - generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vumb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/vumb_front.sv
// ----------------------------------------------------------------------------
// vumb_front - input classifier and job builder
// Takes ticks and palette writes at once; for a level sample it settles the
// bar geometry and colour, forms log2(level) in Q.8 and queues one job.
// ----------------------------------------------------------------------------
`default_nettype none

module vumb_front #(
  parameter int STRIP_LEDS    = vumb_pkg::STRIP_LEDS_DEF,
  parameter int PALETTE_DEPTH = vumb_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  vumb_in_if.sink                 sample,
  input  wire vumb_pkg::cfg_regs_t cfg_regs,
  input  wire logic               mode_wr,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output vumb_pkg::job_t          push_data
);
  import vumb_pkg::*;

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOG  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]          state;
  logic [2:0]          step;
  logic [MANT_W-1:0]   mant;
  logic [EXP_W-1:0]    expo;
  logic [FRAC_W-1:0]   frac;
  logic                lit_en;
  logic [INDEX_W-1:0]  start_q;
  logic [LEN_W-1:0]    len_q;
  logic                cw_q;
  logic                grad_q;
  logic [BRIGHT_W-1:0] bright_q;
  logic                pal_pend;
  logic [COLOR_W-1:0]  live_colour;
  logic [SECS_W-1:0]   seconds_left;
  logic [7:0]          seq_pos;

  logic                accept;
  logic [INDEX_W-1:0]  start_w;
  logic [LEN_W:0]      end_w;
  logic [LEN_W-1:0]    len_w;
  logic [PSIZE_W-1:0]  size_w;
  logic [7:0]          pos_rd;
  logic [PSIZE_W-1:0]  pos_inc;
  logic [7:0]          pos_next;
  logic                recolor;
  logic [EXP_W-1:0]    e_w;
  logic [MANT_W-1:0]   mant0;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_hi;
  logic                pal_we;
  logic [COLOR_W-1:0]  pal_rdata;
  logic [L8_W-1:0]     l8;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);

  // Bar geometry
  always_comb begin
    start_w = ({1'b0, cfg_regs.first_led} >= 7'(STRIP_LEDS)) ? '0 : cfg_regs.first_led;
    end_w   = (LEN_W+1)'(start_w) + (LEN_W+1)'(cfg_regs.bar_length);
    if (cfg_regs.bar_length == '0 || end_w > (LEN_W+1)'(STRIP_LEDS)) begin
      len_w = LEN_W'(STRIP_LEDS) - LEN_W'(start_w);
    end else begin
      len_w = cfg_regs.bar_length;
    end
  end

  // Palette sequence position
  always_comb begin
    if (cfg_regs.palette_size == '0) begin
      size_w = PSIZE_W'(1);
    end else if (cfg_regs.palette_size > PSIZE_W'(PALETTE_DEPTH)) begin
      size_w = PSIZE_W'(PALETTE_DEPTH);
    end else begin
      size_w = cfg_regs.palette_size;
    end
    pos_rd   = ({1'b0, seq_pos} >= size_w) ? '0 : seq_pos;
    pos_inc  = PSIZE_W'(pos_rd) + PSIZE_W'(1);
    pos_next = (pos_inc >= size_w) ? '0 : pos_inc[7:0];
  end

  assign recolor = (cfg_regs.mode_sel == MODE_FIXED || cfg_regs.mode_sel == MODE_SEQUENCE)
                   && (seconds_left == '0);

  // Leading one of the level and normalised mantissa in Q1.31
  always_comb begin
    e_w = '0;
    for (int k = 0; k < LEVEL_W; k++) begin
      if (sample.level[k]) begin
        e_w = EXP_W'(k);
      end
    end
    mant0 = MANT_W'(sample.level) << (5'd31 - {1'b0, e_w});
  end

  // One fraction bit per step: square, and renormalise when at or above 2.0
  assign sq    = 64'(mant) * 64'(mant);
  assign sq_hi = sq[2*MANT_W-1:MANT_W-1];

  assign pal_we = accept && (sample.kind == KIND_PALETTE)
                  && ({1'b0, sample.slot} < PSIZE_W'(PALETTE_DEPTH));

  vumb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (sample.slot[PAL_AW-1:0]),
    .wdata (sample.color_value),
    .raddr (pos_rd[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      pal_pend      <= 1'b0;
      live_colour   <= LIVE_COLOUR_RST;
      seconds_left  <= '0;
      seq_pos       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && sample.kind == KIND_TICK) begin
            if (seconds_left != '0) begin
              seconds_left <= seconds_left - SECS_W'(1);
            end
          end else if (accept && sample.kind == KIND_LEVEL) begin
            state <= ST_LOG;
            step  <= '0;
            if (recolor) begin
              seconds_left <= cfg_regs.recolor_seconds;
              if (cfg_regs.mode_sel == MODE_FIXED) begin
                live_colour <= cfg_regs.fixed_color;
              end else begin
                pal_pend <= 1'b1;
                seq_pos  <= pos_next;
              end
            end
          end
        end
        ST_LOG: begin
          step     <= step + 3'd1;
          pal_pend <= 1'b0;
          if (pal_pend) begin
            live_colour <= pal_rdata;
          end
          if (step == 3'd7) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // A colour mode write restarts the recolour schedule
      if (mode_wr) begin
        seq_pos      <= '0;
        seconds_left <= '0;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && sample.kind == KIND_LEVEL) begin
      mant     <= mant0;
      expo     <= e_w;
      lit_en   <= (sample.level != '0);
      start_q  <= start_w;
      len_q    <= len_w;
      cw_q     <= recolor || (cfg_regs.mode_sel == MODE_GRADIENT);
      grad_q   <= (cfg_regs.mode_sel == MODE_GRADIENT);
      bright_q <= cfg_regs.lit_brightness;
    end else if (state == ST_LOG) begin
      mant <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
      frac <= {frac[FRAC_W-2:0], sq_hi[MANT_W]};
    end
  end

  assign l8 = {expo, frac};

  always_comb begin
    push_valid       = (state == ST_PUSH);
    push_data.start  = start_q;
    push_data.len    = len_q;
    push_data.thr    = THR_W'(19'(l8) * 19'(len_q));
    push_data.lit_en = lit_en;
    push_data.bright = bright_q;
    push_data.cw     = cw_q;
    push_data.grad   = grad_q;
    push_data.color  = live_colour;
  end

  a_pal_capture: assert property (@(posedge clk) disable iff (rst)
    pal_pend |-> (state == ST_LOG && step == 3'd0))
    else $error("palette read data not captured in the first log step");

endmodule

`default_nettype wire

// File: sv/vumb_queue.sv
// ----------------------------------------------------------------------------
// vumb_queue - short job queue between front and back end
// A small register FIFO of bar jobs with valid/ready on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module vumb_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire vumb_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output vumb_pkg::job_t      pop_data
);
  import vumb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop_fire) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("job queue overfilled");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_fire && !pop_fire) |=> (count == $past(count) + CW'(1)))
    else $error("job queue lost a pushed job");

endmodule

`default_nettype wire

// File: sv/vumb_back.sv
// ----------------------------------------------------------------------------
// vumb_back - LED result sequencer
// Walks the bar of the job at the head of the queue into a registered result
// stage, one LED per cycle while the result channel keeps up.
// ----------------------------------------------------------------------------
`default_nettype none

module vumb_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire vumb_pkg::job_t head,
  vumb_out_if.source          result
);
  import vumb_pkg::*;

  logic [INDEX_W-1:0]  led_cnt;
  logic                load;
  logic                at_end;
  logic                lit;
  logic [PCT_W-1:0]    pct_i;
  logic [PCT_W-1:0]    len_p;
  logic [COLOR_W-1:0]  grad_color;
  logic [COLOR_W-1:0]  color_w;

  assign load      = pop_valid && (!result.valid || result.ready);
  assign at_end    = (LEN_W'(led_cnt) + LEN_W'(1)) == head.len;
  assign pop_ready = load && at_end;

  // Lit when i * FULL_LOG <= L8 * len
  assign lit = head.lit_en && ((THR_W'(led_cnt) * THR_W'(FULL_LOG)) <= head.thr);

  // floor(100*i/len) > N is the same as 100*i >= (N+1)*len
  always_comb begin
    pct_i = PCT_W'(led_cnt) * PCT_W'(PCT_FULL);
    len_p = PCT_W'(head.len);
    if (pct_i >= PCT_W'(GRAD_RED_PCT + 1) * len_p) begin
      grad_color = COL_RED;
    end else if (pct_i >= PCT_W'(GRAD_ORANGE_PCT + 1) * len_p) begin
      grad_color = COL_ORANGE;
    end else if (pct_i >= PCT_W'(GRAD_YELLOW_PCT + 1) * len_p) begin
      grad_color = COL_YELLOW;
    end else if (pct_i >= PCT_W'(GRAD_LIME_PCT + 1) * len_p) begin
      grad_color = COL_LIME;
    end else begin
      grad_color = COL_GREEN;
    end
    if (head.grad) begin
      color_w = grad_color;
    end else if (head.cw) begin
      color_w = head.color;
    end else begin
      color_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      led_cnt      <= '0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        led_cnt      <= at_end ? '0 : led_cnt + INDEX_W'(1);
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.led_index      <= head.start + led_cnt;
      result.led_color      <= color_w;
      result.color_write    <= head.cw;
      result.led_brightness <= lit ? head.bright : '0;
      result.last           <= at_end;
    end
  end

  a_cnt_in_bar: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> (LEN_W'(led_cnt) < head.len))
    else $error("LED counter ran past the bar of the head job");

endmodule

`default_nettype wire

// File: sv/vu_meter_bar_driver_unit.sv
// ----------------------------------------------------------------------------
// vu_meter_bar_driver_unit - LED bar graph VU meter driver
// Turns level samples into one LED result per bar position, with fixed,
// palette sequence, keep or green-to-red gradient colouring.
// ----------------------------------------------------------------------------
// A tick or a palette write is taken whenever the front end is idle and
// gives no result. After a level sample the sample channel stays busy while
// the front end forms its eight log2 fraction bits, one per step on one
// shared 32 by 32 squarer, and hands the finished job to a two-entry queue,
// waiting there while the queue is full. The back end then emits one LED
// transaction per cycle while the result channel keeps up. The result stage
// is a register, so the front end carries on with the next sample while
// results wait to be taken. The palette is a plain RAM with no clearing
// pass; entries must be written before the sequence mode reads them.
// Configuration writes are taken at any time (ready is tied high) but are
// meant for an idle block.
// ----------------------------------------------------------------------------
`default_nettype none

module vu_meter_bar_driver_unit #(
  parameter int STRIP_LEDS    = vumb_pkg::STRIP_LEDS_DEF,
  parameter int PALETTE_DEPTH = vumb_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  vumb_in_if.sink    sample,
  vumb_out_if.source result,
  vumb_cfg_if.sink   cfg
);
  import vumb_pkg::*;

  // Configuration register file. Writing the colour mode also restarts the
  // recolour countdown and the palette walk, so the front end sees a pulse.
  cfg_regs_t cfg_regs;
  logic      cfg_fire;
  logic      mode_wr;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.mode_sel        <= MODE_GRADIENT;
      cfg_regs.fixed_color     <= 24'h0000FF;
      cfg_regs.lit_brightness  <= 8'd255;
      cfg_regs.first_led       <= '0;
      cfg_regs.bar_length      <= '0;
      cfg_regs.recolor_seconds <= 16'd60;
      cfg_regs.palette_size    <= 9'd1;
    end else if (cfg_fire) begin
      case (cfg.index)
        REG_COLOR_MODE:      cfg_regs.mode_sel        <= cfg.data[MODE_W-1:0];
        REG_FIXED_COLOR:     cfg_regs.fixed_color     <= cfg.data[COLOR_W-1:0];
        REG_LIT_BRIGHTNESS:  cfg_regs.lit_brightness  <= cfg.data[BRIGHT_W-1:0];
        REG_FIRST_LED:       cfg_regs.first_led       <= cfg.data[INDEX_W-1:0];
        REG_BAR_LENGTH:      cfg_regs.bar_length      <= cfg.data[LEN_W-1:0];
        REG_RECOLOR_SECONDS: cfg_regs.recolor_seconds <= cfg.data[SECS_W-1:0];
        REG_PALETTE_SIZE:    cfg_regs.palette_size    <= cfg.data[PSIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign mode_wr = cfg_fire && (cfg.index == REG_COLOR_MODE);

  // Front end to queue
  logic push_valid;
  logic push_ready;
  job_t push_data;

  // Queue to back end
  logic pop_valid;
  logic pop_ready;
  job_t head;

  vumb_front #(
    .STRIP_LEDS    (STRIP_LEDS),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg_regs   (cfg_regs),
    .mode_wr    (mode_wr),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vumb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (head)
  );

  vumb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .head      (head),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: tb/vumb_led_checker.sv
// ----------------------------------------------------------------------------
// vumb_led_checker - predicts and checks the LED transactions of the driver
// Watches the sample, result and configuration channels, keeps its own copy
// of the registers and the colour state, works out the LED transactions each
// level sample should give and compares them in order with what comes out.
// ----------------------------------------------------------------------------

module vumb_led_checker
  import vumb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  vumb_in_if   smp,
  vumb_out_if  led,
  vumb_cfg_if  cfg,
  output int   failures,
  output int   pending
);

  localparam int STRIP       = STRIP_LEDS_DEF;
  localparam int PALETTE     = PALETTE_DEPTH_DEF;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [INDEX_W-1:0]  idx;
    logic [COLOR_W-1:0]  colour;
    logic                cw;
    logic [BRIGHT_W-1:0] bright;
    logic                last;
  } led_word_t;

  led_word_t expected_leds[$];
  int        errs = 0;

  logic [MODE_W-1:0]   reg_mode;
  logic [COLOR_W-1:0]  reg_fixed;
  logic [BRIGHT_W-1:0] reg_bright;
  logic [INDEX_W-1:0]  reg_first;
  logic [LEN_W-1:0]    reg_len;
  logic [SECS_W-1:0]   reg_recolor;
  logic [PSIZE_W-1:0]  reg_psize;

  logic [COLOR_W-1:0]  palette_ram [PALETTE];
  logic [SLOT_W-1:0]   seq_pos;
  logic [SECS_W-1:0]   secs_left;
  logic [COLOR_W-1:0]  shown_colour;

  assign failures = errs;

  // Integer part from the top set bit, then eight fraction bits by repeated
  // squaring of the mantissa held in Q1.31.
  function automatic logic [L8_W-1:0] level_log2(input logic [LEVEL_W-1:0] v);
    int unsigned     octave;
    logic [63:0]     x;
    logic [L8_W-1:0] r;
    octave = 0;
    while (octave < LEVEL_W - 1 && (v >> (octave + 1)) != 0) octave++;
    x = 64'(v) << (31 - octave);
    r = L8_W'(octave << FRAC_W);
    for (int b = FRAC_W - 1; b >= 0; b--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] band_colour(input int unsigned pos,
                                                     input int unsigned span);
    int unsigned pct;
    pct = (PCT_FULL * pos) / span;
    if (pct > GRAD_RED_PCT)    return COL_RED;
    if (pct > GRAD_ORANGE_PCT) return COL_ORANGE;
    if (pct > GRAD_YELLOW_PCT) return COL_YELLOW;
    if (pct > GRAD_LIME_PCT)   return COL_LIME;
    return COL_GREEN;
  endfunction

  task automatic predict_bar(input logic [LEVEL_W-1:0] level);
    int unsigned start;
    int unsigned span;
    int unsigned l8;
    int unsigned size;
    int unsigned pos;
    logic        recolour;
    led_word_t   w;
    start = reg_first;
    if (start >= STRIP) start = 0;
    span = reg_len;
    if (span == 0 || start + span > STRIP) span = STRIP - start;
    recolour = 1'b0;
    if ((reg_mode == MODE_FIXED || reg_mode == MODE_SEQUENCE) && secs_left == 0) begin
      if (reg_mode == MODE_FIXED) begin
        shown_colour = reg_fixed;
      end else begin
        size = reg_psize;
        if (size == 0) size = 1;
        if (size > PALETTE) size = PALETTE;
        pos = seq_pos;
        if (pos >= size) pos = 0;
        shown_colour = palette_ram[pos];
        pos++;
        if (pos >= size) pos = 0;
        seq_pos = SLOT_W'(pos);
      end
      secs_left = reg_recolor;
      recolour  = 1'b1;
    end
    l8 = (level == 0) ? 0 : level_log2(level);
    for (int unsigned i = 0; i < span; i++) begin
      w.idx = INDEX_W'(start + i);
      if (reg_mode == MODE_GRADIENT) begin
        w.colour = band_colour(i, span);
        w.cw     = 1'b1;
      end else if (recolour) begin
        w.colour = shown_colour;
        w.cw     = 1'b1;
      end else begin
        w.colour = '0;
        w.cw     = 1'b0;
      end
      w.bright = (level != 0 && i * FULL_LOG <= l8 * span) ? reg_bright : '0;
      w.last   = (i + 1 == span);
      expected_leds.push_back(w);
    end
  endtask

  task automatic check_led();
    led_word_t got;
    led_word_t want;
    got.idx    = led.led_index;
    got.colour = led.led_color;
    got.cw     = led.color_write;
    got.bright = led.led_brightness;
    got.last   = led.last;
    if (expected_leds.size() == 0) begin
      errs++;
      if (errs <= MAX_REPORTS)
        $display("%0t: unexpected LED transaction: expected none, actual idx %0d colour %06h",
                 $time, got.idx, got.colour);
    end else begin
      want = expected_leds.pop_front();
      if (got.idx !== want.idx || got.colour !== want.colour || got.cw !== want.cw ||
          got.bright !== want.bright || got.last !== want.last) begin
        errs++;
        if (errs <= MAX_REPORTS) begin
          $display("%0t: LED mismatch: expected idx %0d colour %06h write %0b bright %0d last %0b",
                   $time, want.idx, want.colour, want.cw, want.bright, want.last);
          $display("%0t:                actual idx %0d colour %06h write %0b bright %0d last %0b",
                   $time, got.idx, got.colour, got.cw, got.bright, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reg_mode     = MODE_GRADIENT;
      reg_fixed    = 24'h0000FF;
      reg_bright   = 8'd255;
      reg_first    = '0;
      reg_len      = '0;
      reg_recolor  = 16'd60;
      reg_psize    = 9'd1;
      seq_pos      = '0;
      secs_left    = '0;
      shown_colour = LIVE_COLOUR_RST;
      expected_leds.delete();
    end else begin
      // A result can never belong to a sample taken at the same edge.
      if (led.valid && led.ready) check_led();
      if (smp.valid && smp.ready) begin
        case (smp.kind)
          KIND_LEVEL:   predict_bar(smp.level);
          KIND_TICK:    if (secs_left != 0) secs_left--;
          KIND_PALETTE: palette_ram[smp.slot] = smp.color_value;
          default:      ;
        endcase
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_COLOR_MODE: begin
            reg_mode  = cfg.data[MODE_W-1:0];
            seq_pos   = '0;
            secs_left = '0;
          end
          REG_FIXED_COLOR:     reg_fixed   = cfg.data[COLOR_W-1:0];
          REG_LIT_BRIGHTNESS:  reg_bright  = cfg.data[BRIGHT_W-1:0];
          REG_FIRST_LED:       reg_first   = cfg.data[INDEX_W-1:0];
          REG_BAR_LENGTH:      reg_len     = cfg.data[LEN_W-1:0];
          REG_RECOLOR_SECONDS: reg_recolor = cfg.data[SECS_W-1:0];
          REG_PALETTE_SIZE:    reg_psize   = cfg.data[PSIZE_W-1:0];
          default:             ;
        endcase
      end
    end
    pending <= expected_leds.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the VU meter bar driver
// Fills the palette, runs a directed set of samples through every colour mode
// and bar corner, then random register settings with random traffic, while
// both channels idle at random and the result side once holds off for long.
// ----------------------------------------------------------------------------

module testbench;
  import vumb_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 80;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 6;
  localparam int SQUEEZE_ITEMS  = 16;
  localparam int SQUEEZE_PHASE  = 2;
  localparam int CALM_PHASE     = 4;
  // No phase walks the palette sequence further than this many entries.
  localparam int PALETTE_FILL   = 16;

  // Codes that the block has no meaning for; it must ignore them.
  localparam logic [KIND_W-1:0]   KIND_SPARE = 2'd3;
  localparam logic [REGIDX_W-1:0] REG_SPARE  = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        calm = 1'b0;
  logic        squeeze_req = 1'b0;
  logic        squeeze_done = 1'b0;
  int          fail_count;
  int          pending_leds;
  int unsigned cycle_count;

  vumb_in_if  smp_ch ();
  vumb_out_if led_ch ();
  vumb_cfg_if cfg_ch ();

  vu_meter_bar_driver_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_ch),
    .result (led_ch),
    .cfg    (cfg_ch)
  );

  // The checker sits beside the block and only watches the three channels.
  vumb_led_checker led_check (
    .clk      (clk),
    .rst      (rst),
    .smp      (smp_ch),
    .led      (led_ch),
    .cfg      (cfg_ch),
    .failures (fail_count),
    .pending  (pending_leds)
  );

  always #HALF_PERIOD clk = ~clk;

  // Gap lengths shared by both sides: mostly none, often a few cycles, now
  // and then a long one. In a calm phase neither side idles at all.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Levels lean towards the interesting spots of the log curve: zero, exact
  // powers of two, all-ones patterns, small values and the saturated top half.
  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1);
      2:       return LEVEL_W'((32'd1 << $urandom_range(1, LEVEL_W)) - 1);
      3:       return LEVEL_W'($urandom_range(32768, 65535));
      4:       return LEVEL_W'($urandom_range(1, 255));
      default: return LEVEL_W'($urandom());
    endcase
  endfunction

  // One sample-channel transaction. Valid is only lowered when a gap is
  // wanted, so back-to-back transactions keep it high without a glitch.
  task automatic send_item(input logic [KIND_W-1:0]  kind,
                           input logic [LEVEL_W-1:0] level,
                           input logic [SLOT_W-1:0]  slot,
                           input logic [COLOR_W-1:0] colour);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_ch.valid       <= 1'b1;
    smp_ch.kind        <= kind;
    smp_ch.level       <= level;
    smp_ch.slot        <= slot;
    smp_ch.color_value <= colour;
    do @(posedge clk); while (smp_ch.ready !== 1'b1);
  endtask

  // Fields that a transaction does not use still get random values, so that
  // every bit of the channel moves.
  task automatic send_level(input logic [LEVEL_W-1:0] level);
    send_item(KIND_LEVEL, level, SLOT_W'($urandom()), COLOR_W'($urandom()));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, LEVEL_W'($urandom()), SLOT_W'($urandom()), COLOR_W'($urandom()));
  endtask

  task automatic send_palette(input logic [SLOT_W-1:0] slot, input logic [COLOR_W-1:0] colour);
    send_item(KIND_PALETTE, LEVEL_W'($urandom()), slot, colour);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)      send_level(pick_level());
    else if (r < 85) send_tick();
    else if (r < 95) send_palette(SLOT_W'($urandom()), COLOR_W'($urandom()));
    else             send_item(KIND_SPARE, LEVEL_W'($urandom()), SLOT_W'($urandom()),
                               COLOR_W'($urandom()));
  endtask

  // Waits for every expected LED transaction, then a short pause so that a
  // tick or palette write still in the front end is taken before any
  // register changes.
  task automatic settle();
    @(negedge clk);
    smp_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_leds != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [CFGDAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // The colour mode goes first, since writing it restarts the palette
  // sequence and the recolour countdown.
  task automatic configure(input logic [MODE_W-1:0]   mode,
                           input logic [COLOR_W-1:0]  colour,
                           input logic [BRIGHT_W-1:0] bright,
                           input logic [INDEX_W-1:0]  first,
                           input logic [LEN_W-1:0]    len,
                           input logic [SECS_W-1:0]   secs,
                           input logic [PSIZE_W-1:0]  psize);
    write_reg(REG_COLOR_MODE,      CFGDAT_W'(mode));
    write_reg(REG_FIXED_COLOR,     CFGDAT_W'(colour));
    write_reg(REG_LIT_BRIGHTNESS,  CFGDAT_W'(bright));
    write_reg(REG_FIRST_LED,       CFGDAT_W'(first));
    write_reg(REG_BAR_LENGTH,      CFGDAT_W'(len));
    write_reg(REG_RECOLOR_SECONDS, CFGDAT_W'(secs));
    write_reg(REG_PALETTE_SIZE,    CFGDAT_W'(psize));
  endtask

  // Random register settings. Most bars are short to keep the run quick;
  // a few fill to the strip end or overrun it, and sizes and countdowns hit
  // their extremes now and then.
  task automatic random_setup();
    int                  r;
    logic [BRIGHT_W-1:0] bright;
    logic [INDEX_W-1:0]  first;
    logic [LEN_W-1:0]    len;
    logic [SECS_W-1:0]   secs;
    logic [PSIZE_W-1:0]  psize;
    r = $urandom_range(0, 99);
    bright = (r < 15) ? '0 : (r < 30) ? '1 : BRIGHT_W'($urandom());
    r = $urandom_range(0, 99);
    first = INDEX_W'($urandom_range(0, STRIP_LEDS_DEF - 1));
    if (r < 12)      len = '0;
    else if (r < 22) len = LEN_W'($urandom_range(STRIP_LEDS_DEF + 1, 127));
    else if (r < 27) begin
      first = '0;
      len   = LEN_W'(STRIP_LEDS_DEF);
    end
    else             len = LEN_W'($urandom_range(1, 12));
    r = $urandom_range(0, 99);
    secs = (r < 10) ? '1 : (r < 20) ? '0 : SECS_W'($urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 10)      psize = '0;
    else if (r < 20) psize = PSIZE_W'($urandom_range(PALETTE_DEPTH_DEF + 1, 511));
    else if (r < 25) psize = PSIZE_W'(PALETTE_DEPTH_DEF);
    else             psize = PSIZE_W'($urandom_range(1, 8));
    configure(MODE_W'($urandom_range(0, 3)), COLOR_W'($urandom()), bright, first, len,
              secs, psize);
  endtask

  // Cycle counter that ends a run which has stopped making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Result side: random stalls, and once on request a long hold-off while
  // the sample side keeps offering levels, so the job queue fills and the
  // block has to push back on its input.
  initial begin
    int stall;
    stall = 0;
    led_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        stall = SQUEEZE_CYCLES;
      end
      if (stall > 0) begin
        led_ch.ready <= 1'b0;
        stall--;
      end else begin
        led_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    smp_ch.valid       = 1'b0;
    smp_ch.kind        = KIND_LEVEL;
    smp_ch.level       = '0;
    smp_ch.slot        = '0;
    smp_ch.color_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_COLOR_MODE;
    cfg_ch.data        = '0;
    rst                = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The palette has no defined contents after reset. Every mode write
    // restarts the sequence at the first entry and no phase gives more than
    // sixteen samples, so the first sixteen entries are all it can reach.
    for (int s = 0; s < PALETTE_FILL; s++)
      send_palette(SLOT_W'(s), COLOR_W'($urandom()));

    // Reset settings: gradient over the whole strip. Zero lights nothing, one
    // lights only the first LED, full scale and above light every LED.
    send_level(16'd0);
    send_level(16'd1);
    send_level(16'd2);
    send_level(16'd255);
    send_level(16'd32767);
    send_level(16'd32768);
    send_level(16'hFFFF);
    send_tick();
    send_item(KIND_SPARE, LEVEL_W'($urandom()), SLOT_W'($urandom()), COLOR_W'($urandom()));
    send_palette('1, '1);

    // Fixed colour, brightness zero, and a bar that overruns the strip end
    // so it is cut to the last four LEDs. The countdown of two seconds means
    // only the first and the last sample recolour; the extra tick checks that
    // the count holds at zero.
    settle();
    write_reg(REG_SPARE, CFGDAT_W'($urandom()));
    configure(MODE_FIXED, COLOR_W'($urandom()), '0, INDEX_W'(60), LEN_W'(10), SECS_W'(2),
              PSIZE_W'(1));
    send_level(16'hFFFF);
    send_tick();
    send_level(16'd32768);
    send_tick();
    send_tick();
    send_level(16'd1000);

    // Palette sequence on the single last LED, recolouring on every sample
    // because the countdown reloads with zero.
    settle();
    configure(MODE_SEQUENCE, '1, '1, INDEX_W'(63), LEN_W'(1), '0, PSIZE_W'(5));
    repeat (4) send_level(pick_level());

    // Shrinking the palette without a mode write leaves the position past
    // the new size, which must fall back to the first entry. A size of zero
    // acts as one, and one above the depth acts as the full depth.
    settle();
    write_reg(REG_PALETTE_SIZE, CFGDAT_W'(0));
    send_level(pick_level());
    settle();
    write_reg(REG_PALETTE_SIZE, CFGDAT_W'(511));
    send_level(pick_level());
    send_level(pick_level());

    // Keep mode writes no colour; the overlong bar fills to the strip end.
    settle();
    configure(MODE_KEEP, COLOR_W'($urandom()), BRIGHT_W'($urandom()), INDEX_W'(40),
              LEN_W'(127), SECS_W'($urandom()), PSIZE_W'(PALETTE_DEPTH_DEF));
    send_level(16'd20000);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      random_setup();
      calm = (ph == CALM_PHASE);
      if (ph == SQUEEZE_PHASE) begin
        squeeze_req = 1'b1;
        repeat (SQUEEZE_ITEMS) send_level(pick_level());
      end else begin
        repeat (PHASE_ITEMS) random_item();
      end
    end

    @(negedge clk);
    smp_ch.valid <= 1'b0;
    calm = 1'b0;
    do @(posedge clk); while (pending_leds != 0);
    // Any stray LED transaction after the last expected one is caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: sim.f
sv/vumb_pkg.sv
sv/vumb_if.sv
sv/vumb_ram.sv
sv/vumb_front.sv
sv/vumb_queue.sv
sv/vumb_back.sv
sv/vu_meter_bar_driver_unit.sv
tb/vumb_led_checker.sv
tb/testbench.sv
